### rtl/fcg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcg_pkg: shared types and constants of the 5x5 character generator
// Screen size, action codes, job format between the front end and the row
// emitter, and the 36-glyph font table.
// ----------------------------------------------------------------------------
package fcg_pkg;

    // screen geometry
    localparam int SCREEN_ROWS = 64;
    localparam int SCREEN_COLS = 128;
    localparam logic [7:0] EDGE_LIMIT = 8'(SCREEN_COLS - 6);

    // cursor advances
    localparam logic [7:0] GLYPH_ADVANCE = 8'd6;
    localparam logic [7:0] SPACE_ADVANCE = 8'd4;

    // geometry of one glyph
    localparam int GLYPH_ROWS  = 5;
    localparam int GLYPH_COUNT = 36;
    localparam int GLYPH_W     = $clog2(GLYPH_COUNT);
    localparam int ROM_DEPTH   = GLYPH_COUNT * GLYPH_ROWS;
    localparam int ROM_AW      = $clog2(ROM_DEPTH);
    localparam logic [2:0] LAST_ROW = 3'(GLYPH_ROWS - 1);

    // job queue geometry
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // action codes of an input item
    typedef enum logic [1:0] {
        ACT_START  = 2'd0,
        ACT_CHAR   = 2'd1,
        ACT_NUMBER = 2'd2
    } action_t;

    // one drawing job: up to three glyphs placed side by side
    typedef struct packed {
        logic [7:0]         x;
        logic [7:0]         y;
        logic [1:0]         cnt;
        logic [GLYPH_W-1:0] g0;
        logic [GLYPH_W-1:0] g1;
        logic [GLYPH_W-1:0] g2;
    } job_t;

    // front end to queue
    typedef struct packed {
        logic push;
        job_t job;
    } job_req_t;

    // queue head to row emitter
    typedef struct packed {
        logic valid;
        job_t job;
    } job_head_t;

    // font rows, five per glyph, digits then A-Z, bit 4 leftmost
    localparam logic [4:0] GLYPH_ROM [ROM_DEPTH] = '{
        5'h0E, 5'h11, 5'h11, 5'h11, 5'h0E,  5'h04, 5'h0C, 5'h04, 5'h04, 5'h0E,
        5'h0E, 5'h01, 5'h0E, 5'h10, 5'h0F,  5'h0F, 5'h01, 5'h07, 5'h01, 5'h0F,
        5'h11, 5'h11, 5'h0F, 5'h01, 5'h01,  5'h0F, 5'h10, 5'h0E, 5'h01, 5'h0E,
        5'h0E, 5'h10, 5'h0E, 5'h11, 5'h0E,  5'h1F, 5'h01, 5'h02, 5'h04, 5'h04,
        5'h0E, 5'h11, 5'h0E, 5'h11, 5'h0E,  5'h0E, 5'h11, 5'h0F, 5'h01, 5'h0E,
        5'h0E, 5'h11, 5'h1F, 5'h11, 5'h11,  5'h1E, 5'h11, 5'h1E, 5'h11, 5'h1E,
        5'h0E, 5'h11, 5'h10, 5'h11, 5'h0E,  5'h1E, 5'h11, 5'h11, 5'h11, 5'h1E,
        5'h1F, 5'h10, 5'h1E, 5'h10, 5'h1F,  5'h1F, 5'h10, 5'h1E, 5'h10, 5'h10,
        5'h0E, 5'h11, 5'h13, 5'h11, 5'h0F,  5'h11, 5'h11, 5'h1F, 5'h11, 5'h11,
        5'h0E, 5'h04, 5'h04, 5'h04, 5'h0E,  5'h07, 5'h02, 5'h02, 5'h12, 5'h0C,
        5'h11, 5'h12, 5'h1C, 5'h12, 5'h11,  5'h10, 5'h10, 5'h10, 5'h10, 5'h1F,
        5'h11, 5'h1B, 5'h15, 5'h11, 5'h11,  5'h11, 5'h19, 5'h15, 5'h13, 5'h11,
        5'h0E, 5'h11, 5'h11, 5'h11, 5'h0E,  5'h1E, 5'h11, 5'h1E, 5'h10, 5'h10,
        5'h0E, 5'h11, 5'h15, 5'h12, 5'h0D,  5'h1E, 5'h11, 5'h1E, 5'h12, 5'h11,
        5'h0F, 5'h10, 5'h0E, 5'h01, 5'h1E,  5'h1F, 5'h04, 5'h04, 5'h04, 5'h04,
        5'h11, 5'h11, 5'h11, 5'h11, 5'h0E,  5'h11, 5'h11, 5'h0A, 5'h0A, 5'h04,
        5'h11, 5'h15, 5'h15, 5'h15, 5'h0A,  5'h11, 5'h0A, 5'h04, 5'h0A, 5'h11,
        5'h11, 5'h0A, 5'h04, 5'h04, 5'h04,  5'h1F, 5'h02, 5'h04, 5'h08, 5'h1F
    };

    // one font row of glyph gi
    function automatic logic [4:0] glyph_row(input logic [GLYPH_W-1:0] gi,
                                             input logic [2:0] r);
        logic [ROM_AW-1:0] idx;
        idx = ROM_AW'(gi) * ROM_AW'(GLYPH_ROWS) + ROM_AW'(r);
        return GLYPH_ROM[idx];
    endfunction

endpackage

### rtl/font_5x5_character_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// font_5x5_character_generator: 5x5 bitmap text generator
// Cursor-based character and number drawing for a small pixel screen.
// ----------------------------------------------------------------------------
// The block emits one font row per clock unless out_stall holds it: a drawn
// character gives five rows at the output, a number up to fifteen, and items
// that draw nothing (start, space, skipped codes) make no job. The front end
// takes an item every cycle while the four-entry job queue has room, so the
// row emitter, at one row per cycle while out_stall is low, sets the sustained rate. Each result
// carries the glyph column, the screen row and five pixels, with last high
// on the final row of its item.
module font_5x5_character_generator (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  action,
    input  logic [7:0]  pos_x,
    input  logic [7:0]  pos_y,
    input  logic [7:0]  char_code,
    input  logic [15:0] number,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [6:0]  row_x,
    output logic [7:0]  row_y,
    output logic [4:0]  row_bits,
    output logic        last
);
    import fcg_pkg::*;

    job_req_t  req;
    job_head_t head;
    logic      q_full;
    logic      pop;

    // classifier and cursor
    fcg_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .action    (action),
        .pos_x     (pos_x),
        .pos_y     (pos_y),
        .char_code (char_code),
        .number    (number),
        .q_full    (q_full),
        .req       (req)
    );

    // job queue
    fcg_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .full  (q_full),
        .head  (head),
        .pop   (pop)
    );

    // row emitter
    fcg_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .row_x     (row_x),
        .row_y     (row_y),
        .row_bits  (row_bits),
        .last      (last)
    );

endmodule

### rtl/fcg_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcg_front: item classifier and cursor keeper
// Takes input items, tracks cursor and stopped flag, splits numbers into
// digits and turns every item that draws into a job for the queue.
// ----------------------------------------------------------------------------
module fcg_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [1:0]       action,
    input  logic [7:0]       pos_x,
    input  logic [7:0]       pos_y,
    input  logic [7:0]       char_code,
    input  logic [15:0]      number,
    input  logic             q_full,
    output fcg_pkg::job_req_t req
);
    import fcg_pkg::*;

    localparam logic [7:0]  CH_NUL    = 8'h00;
    localparam logic [7:0]  CH_SPACE  = 8'h20;
    localparam logic [7:0]  CH_ZERO   = 8'h30;
    localparam logic [7:0]  CH_NINE   = 8'h39;
    localparam logic [7:0]  CH_UPPER_A = 8'h41;
    localparam logic [7:0]  CH_UPPER_Z = 8'h5A;
    localparam logic [7:0]  CH_LOWER_A = 8'h61;
    localparam logic [7:0]  CASE_FOLD = 8'h20;
    localparam logic [15:0] NUM_MAX   = 16'd999;

    logic [7:0] cursor_x_reg, cursor_x_next;
    logic [7:0] cursor_y_reg, cursor_y_next;
    logic       stopped_reg, stopped_next;
    logic       accept;

    logic [9:0]         num_clamp;
    logic [15:0]        prod_hund;
    logic [3:0]         dig_hund;
    logic [6:0]         rem_hund;
    logic [14:0]        prod_ten;
    logic [3:0]         dig_ten;
    logic [3:0]         dig_one;
    logic [1:0]         num_cnt;
    logic [GLYPH_W-1:0] num_g0, num_g1, num_g2;

    logic [1:0]         emit_cnt;
    logic [GLYPH_W-1:0] char_glyph;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;

    // decimal digits of the clamped value by reciprocal multiplication
    always_comb
    begin
        num_clamp = (number > NUM_MAX) ? NUM_MAX[9:0] : number[9:0];
        prod_hund = 16'(num_clamp) * 16'd41;
        dig_hund  = prod_hund[15:12];
        rem_hund  = 7'(num_clamp - 10'(10'(dig_hund) * 10'd100));
        prod_ten  = 15'(rem_hund) * 15'd205;
        dig_ten   = prod_ten[14:11];
        dig_one   = 4'(rem_hund - 7'(7'(dig_ten) * 7'd10));
        if (num_clamp >= 10'd100)
        begin
            num_cnt = 2'd3;
            num_g0  = GLYPH_W'(dig_hund);
            num_g1  = GLYPH_W'(dig_ten);
            num_g2  = GLYPH_W'(dig_one);
        end
        else if (num_clamp >= 10'd10)
        begin
            num_cnt = 2'd2;
            num_g0  = GLYPH_W'(dig_ten);
            num_g1  = GLYPH_W'(dig_one);
            num_g2  = '0;
        end
        else
        begin
            num_cnt = 2'd1;
            num_g0  = GLYPH_W'(dig_one);
            num_g1  = '0;
            num_g2  = '0;
        end
    end

    // classification, edge test and cursor advance
    always_comb
    begin
        logic [7:0] fold;
        logic [7:0] sx;
        logic       st;
        logic       done;
        cursor_x_next = cursor_x_reg;
        cursor_y_next = cursor_y_reg;
        stopped_next  = stopped_reg;
        emit_cnt      = 2'd0;
        char_glyph    = '0;
        fold          = char_code;
        sx            = cursor_x_reg;
        st            = stopped_reg;
        done          = 1'b0;
        case (action)
            ACT_START:
            begin
                cursor_x_next = pos_x;
                cursor_y_next = pos_y;
                stopped_next  = 1'b0;
            end
            ACT_CHAR:
            begin
                if (char_code != CH_NUL && !stopped_reg)
                begin
                    if (cursor_x_reg > EDGE_LIMIT)
                        stopped_next = 1'b1;
                    else if (char_code == CH_SPACE)
                        cursor_x_next = cursor_x_reg + SPACE_ADVANCE;
                    else
                    begin
                        if (char_code >= CH_LOWER_A)
                            fold = char_code - CASE_FOLD;
                        if (fold >= CH_ZERO && fold <= CH_NINE)
                        begin
                            char_glyph    = GLYPH_W'(fold - CH_ZERO);
                            emit_cnt      = 2'd1;
                            cursor_x_next = cursor_x_reg + GLYPH_ADVANCE;
                        end
                        else if (fold >= CH_UPPER_A && fold <= CH_UPPER_Z)
                        begin
                            char_glyph    = GLYPH_W'(fold - CH_UPPER_A + 8'd10);
                            emit_cnt      = 2'd1;
                            cursor_x_next = cursor_x_reg + GLYPH_ADVANCE;
                        end
                    end
                end
            end
            ACT_NUMBER:
            begin
                // an edge test for each digit, from the hundreds down to the ones
                for (int j = 0; j < 3; j++)
                begin
                    if (!done && (2'(j) < num_cnt))
                    begin
                        if (st)
                            done = 1'b1;
                        else if (sx > EDGE_LIMIT)
                        begin
                            st   = 1'b1;
                            done = 1'b1;
                        end
                        else
                        begin
                            emit_cnt = emit_cnt + 2'd1;
                            sx       = sx + GLYPH_ADVANCE;
                        end
                    end
                end
                cursor_x_next = sx;
                stopped_next  = st;
            end
            default:
            begin
                cursor_x_next = cursor_x_reg;
            end
        endcase
    end

    // job toward the queue
    always_comb
    begin
        req.push    = accept && (emit_cnt != 2'd0);
        req.job.x   = cursor_x_reg;
        req.job.y   = cursor_y_reg;
        req.job.cnt = emit_cnt;
        if (action == ACT_CHAR)
        begin
            req.job.g0 = char_glyph;
            req.job.g1 = '0;
            req.job.g2 = '0;
        end
        else
        begin
            req.job.g0 = num_g0;
            req.job.g1 = num_g1;
            req.job.g2 = num_g2;
        end
    end

    // cursor state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_x_reg <= 8'd0;
            cursor_y_reg <= 8'd0;
            stopped_reg  <= 1'b0;
        end
        else if (accept)
        begin
            cursor_x_reg <= cursor_x_next;
            cursor_y_reg <= cursor_y_next;
            stopped_reg  <= stopped_next;
        end
    end

endmodule

### rtl/fcg_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcg_queue: job queue between front end and row emitter
// Small circular buffer of drawing jobs; the head is shown to the emitter.
// ----------------------------------------------------------------------------
module fcg_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  fcg_pkg::job_req_t  req,
    output logic               full,
    output fcg_pkg::job_head_t head,
    input  logic               pop
);
    import fcg_pkg::*;

    job_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    assign full       = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign do_push    = req.push && !full;
    assign do_pop     = pop && (count_reg != '0);
    assign head.valid = (count_reg != '0);
    assign head.job   = slot_reg[rd_ptr_reg];

    // pointer and fill count
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // job storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= req.job;
    end

`ifndef NO_ASSERTIONS
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue fill count out of range");
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !req.push)
        else $error("job pushed into a full queue");
    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        QPTR_W'(wr_ptr_reg - rd_ptr_reg) == QPTR_W'(count_reg))
        else $error("queue pointers disagree with fill count");
`endif

endmodule

### rtl/fcg_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcg_back: glyph row emitter
// Walks the glyphs and rows of the head job, one font row per cycle while
// the output is not stalled, into the output register.
// ----------------------------------------------------------------------------
module fcg_back (
    input  logic               clk,
    input  logic               rst_n,
    input  fcg_pkg::job_head_t head,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [6:0]         row_x,
    output logic [7:0]         row_y,
    output logic [4:0]         row_bits,
    output logic               last
);
    import fcg_pkg::*;

    logic [1:0]         glyph_sel_reg, glyph_sel_next;
    logic [2:0]         row_reg, row_next;
    logic               out_valid_reg, out_valid_next;
    logic [6:0]         row_x_reg, row_x_next;
    logic [7:0]         row_y_reg, row_y_next;
    logic [4:0]         row_bits_reg, row_bits_next;
    logic               last_reg, last_next;
    logic               advance;
    logic               last_glyph;
    logic [GLYPH_W-1:0] cur_glyph;
    logic [7:0]         cur_x;

    assign advance    = head.valid && (!out_valid_reg || !out_stall);
    assign last_glyph = (glyph_sel_reg == head.job.cnt - 2'd1);
    assign pop        = advance && (row_reg == LAST_ROW) && last_glyph;

    // glyph in work and its column
    always_comb
    begin
        case (glyph_sel_reg)
            2'd0:    cur_glyph = head.job.g0;
            2'd1:    cur_glyph = head.job.g1;
            default: cur_glyph = head.job.g2;
        endcase
        cur_x = head.job.x + 8'({glyph_sel_reg, 2'b00}) + 8'({glyph_sel_reg, 1'b0});
    end

    // row walk and output register load
    always_comb
    begin
        glyph_sel_next = glyph_sel_reg;
        row_next       = row_reg;
        row_x_next     = row_x_reg;
        row_y_next     = row_y_reg;
        row_bits_next  = row_bits_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg && out_stall;
        if (advance)
        begin
            out_valid_next = 1'b1;
            row_x_next     = cur_x[6:0];
            row_y_next     = head.job.y + 8'(row_reg);
            row_bits_next  = (9'(row_y_next) < 9'(SCREEN_ROWS))
                           ? glyph_row(cur_glyph, row_reg) : 5'd0;
            last_next      = (row_reg == LAST_ROW) && last_glyph;
            if (row_reg == LAST_ROW)
            begin
                row_next       = 3'd0;
                glyph_sel_next = last_glyph ? 2'd0 : glyph_sel_reg + 2'd1;
            end
            else
                row_next = row_reg + 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            glyph_sel_reg <= 2'd0;
            row_reg       <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            glyph_sel_reg <= glyph_sel_next;
            row_reg       <= row_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        row_x_reg    <= row_x_next;
        row_y_reg    <= row_y_next;
        row_bits_reg <= row_bits_next;
        last_reg     <= last_next;
    end

    assign out_valid = out_valid_reg;
    assign row_x     = row_x_reg;
    assign row_y     = row_y_reg;
    assign row_bits  = row_bits_reg;
    assign last      = last_reg;

`ifndef NO_ASSERTIONS
    a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
        row_reg <= LAST_ROW)
        else $error("glyph row counter out of range");
    a_glyph_in_job: assert property (@(posedge clk) disable iff (!rst_n)
        head.valid |-> (glyph_sel_reg < head.job.cnt))
        else $error("glyph select beyond job length");
    a_pop_marks_last: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (out_valid_reg && last_reg && row_reg == 3'd0 && glyph_sel_reg == 2'd0))
        else $error("job retired without a final row");
`endif

endmodule
